// ----- rtl/pfad_pkg.sv -----
package pfad_pkg;

	// coefficient store sizing
	localparam int MAX_COEFFS = 16;
	localparam int COEF_AW    = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
	localparam int CNT_W      = $clog2(MAX_COEFFS + 1);

	// binary64 constants
	localparam logic [63:0] TWO_PI_BITS = 64'h401921FB54442D18;
	localparam logic [63:0] DEFAULT_NAN = 64'hFFF8000000000000;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_PARAM  = 2'd1,
		KIND_EMIT   = 2'd2,
		KIND_CHUNK  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		FOP_ADD  = 2'd0,
		FOP_MUL  = 2'd1,
		FOP_CVTF = 2'd2,
		FOP_CVTI = 2'd3
	} fop_t;

	typedef struct packed {
		logic        start;
		fop_t        op;
		logic [63:0] a;
		logic [63:0] b;
	} fpu_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] res;
	} fpu_rsp_t;

endpackage

// ----- rtl/pfad_fpu.sv -----
// Shared binary64 unit: add, multiply, binary32 widen, byte to double.
// Multiply uses one 27x27 multiplier over four partial products.
// Normalize walks the significand 16 or 1 bit per cycle, then rounds RNE.
module pfad_fpu (
	input  logic               clk,
	input  logic               arst_n,
	input  pfad_pkg::fpu_req_t req,
	output pfad_pkg::fpu_rsp_t rsp
);
	import pfad_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_ALIGN = 5'b00010,
		S_MUL   = 5'b00100,
		S_NORM  = 5'b01000,
		S_ROUND = 5'b10000
	} fst_t;

	fst_t               st_q;
	logic               done_q;
	logic [63:0]        res_q;
	logic               sign_q;
	logic               zs_q;
	logic               sub_q;
	logic signed [13:0] eb_q;
	logic [127:0]       m_q;
	logic [52:0]        ma_q;
	logic [52:0]        mb_q;
	logic [10:0]        d_q;
	logic [2:0]         cnt_q;
	logic [53:0]        pp_q;
	logic [1:0]         ppsh_q;

	// operand decode
	logic [10:0] a_e, b_e, a_ee, b_ee;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [52:0] a_m, b_m;
	logic        a_ge;
	logic [63:0] big, lesser;
	logic [10:0] big_e, small_e;
	logic [52:0] big_m, small_m;
	logic signed [13:0] mul_eb;
	logic [7:0]  f_e;
	logic [22:0] f_f;
	logic [7:0]  f_ee;

	assign a_e    = req.a[62:52];
	assign b_e    = req.b[62:52];
	assign a_ee   = (a_e == 11'd0) ? 11'd1 : a_e;
	assign b_ee   = (b_e == 11'd0) ? 11'd1 : b_e;
	assign a_nan  = (a_e == 11'h7FF) && (req.a[51:0] != 52'd0);
	assign b_nan  = (b_e == 11'h7FF) && (req.b[51:0] != 52'd0);
	assign a_inf  = (a_e == 11'h7FF) && (req.a[51:0] == 52'd0);
	assign b_inf  = (b_e == 11'h7FF) && (req.b[51:0] == 52'd0);
	assign a_zero = (req.a[62:0] == 63'd0);
	assign b_zero = (req.b[62:0] == 63'd0);
	assign a_m    = {a_e != 11'd0, req.a[51:0]};
	assign b_m    = {b_e != 11'd0, req.b[51:0]};
	assign a_ge   = (req.a[62:0] >= req.b[62:0]);
	assign big    = a_ge ? req.a : req.b;
	assign lesser = a_ge ? req.b : req.a;
	assign big_e  = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
	assign small_e = (lesser[62:52] == 11'd0) ? 11'd1 : lesser[62:52];
	assign big_m  = {big[62:52] != 11'd0, big[51:0]};
	assign small_m = {lesser[62:52] != 11'd0, lesser[51:0]};
	assign mul_eb = $signed({3'b000, a_ee}) + $signed({3'b000, b_ee}) - 14'sd1022;
	assign f_e    = req.a[30:23];
	assign f_f    = req.a[22:0];
	assign f_ee   = (f_e == 8'd0) ? 8'd1 : f_e;

	// alignment add
	logic [127:0] al_a, al_b, al_sh, al_bs, al_sum;
	logic         al_st;
	always_comb begin
		al_a = {1'b0, ma_q, 74'd0};
		al_b = {1'b0, mb_q, 74'd0};
		if (d_q >= 11'd128) begin
			al_sh = 128'd0;
			al_st = |mb_q;
		end else begin
			al_sh = al_b >> d_q[6:0];
			al_st = |(al_b & ~({128{1'b1}} << d_q[6:0]));
		end
		al_bs  = {al_sh[127:1], al_sh[0] | al_st};
		al_sum = sub_q ? (al_a - al_bs) : (al_a + al_bs);
	end

	// partial products
	logic [26:0]  mx, my;
	logic [53:0]  pp_n;
	logic [127:0] ppadd;
	assign mx   = cnt_q[1] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
	assign my   = cnt_q[0] ? {1'b0, mb_q[52:27]} : mb_q[26:0];
	assign pp_n = 54'(mx) * 54'(my);
	always_comb begin
		case (ppsh_q)
			2'd0:    ppadd = {52'd0, pp_q, 22'd0};
			2'd1:    ppadd = {25'd0, pp_q, 49'd0};
			2'd2:    ppadd = {pp_q[51:0], 76'd0};
			default: ppadd = 128'd0;
		endcase
	end

	// round to nearest even
	logic [52:0] rt;
	logic        rg, rs, rinc, ovf;
	logic [10:0] rexp;
	logic [62:0] rnd;
	assign rt   = m_q[127:75];
	assign rg   = m_q[74];
	assign rs   = |m_q[73:0];
	assign rinc = rg & (rs | rt[0]);
	assign rexp = rt[52] ? eb_q[10:0] : 11'd0;
	assign rnd  = {rexp, rt[51:0]} + {62'd0, rinc};
	assign ovf  = (eb_q >= 14'sd2047);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			done_q <= 1'b0;
			res_q  <= 64'd0;
			sign_q <= 1'b0;
			zs_q   <= 1'b0;
			sub_q  <= 1'b0;
			eb_q   <= 14'sd0;
			m_q    <= 128'd0;
			ma_q   <= 53'd0;
			mb_q   <= 53'd0;
			d_q    <= 11'd0;
			cnt_q  <= 3'd0;
			pp_q   <= 54'd0;
			ppsh_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (req.start) begin
						case (req.op)
							FOP_ADD: begin
								if (a_nan) begin
									res_q <= req.a | 64'h0008000000000000;
									done_q <= 1'b1;
								end else if (b_nan) begin
									res_q <= req.b | 64'h0008000000000000;
									done_q <= 1'b1;
								end else if (a_inf && b_inf && (req.a[63] != req.b[63])) begin
									res_q <= DEFAULT_NAN;
									done_q <= 1'b1;
								end else if (a_inf) begin
									res_q <= req.a;
									done_q <= 1'b1;
								end else if (b_inf) begin
									res_q <= req.b;
									done_q <= 1'b1;
								end else begin
									ma_q   <= big_m;
									mb_q   <= small_m;
									d_q    <= big_e - small_e;
									sub_q  <= req.a[63] ^ req.b[63];
									sign_q <= big[63];
									zs_q   <= req.a[63] & req.b[63];
									eb_q   <= $signed({3'b000, big_e}) + 14'sd1;
									st_q   <= S_ALIGN;
								end
							end
							FOP_MUL: begin
								if (a_nan) begin
									res_q <= req.a | 64'h0008000000000000;
									done_q <= 1'b1;
								end else if (b_nan) begin
									res_q <= req.b | 64'h0008000000000000;
									done_q <= 1'b1;
								end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
									res_q <= DEFAULT_NAN;
									done_q <= 1'b1;
								end else if (a_inf || b_inf) begin
									res_q <= {req.a[63] ^ req.b[63], 11'h7FF, 52'd0};
									done_q <= 1'b1;
								end else if (a_zero || b_zero) begin
									res_q <= {req.a[63] ^ req.b[63], 63'd0};
									done_q <= 1'b1;
								end else begin
									ma_q   <= a_m;
									mb_q   <= b_m;
									sign_q <= req.a[63] ^ req.b[63];
									eb_q   <= mul_eb;
									m_q    <= 128'd0;
									cnt_q  <= 3'd0;
									st_q   <= S_MUL;
								end
							end
							FOP_CVTF: begin
								if (f_e == 8'hFF) begin
									if (f_f != 23'd0)
										res_q <= {req.a[31], 11'h7FF, 1'b1, f_f[21:0], 29'd0};
									else
										res_q <= {req.a[31], 11'h7FF, 52'd0};
									done_q <= 1'b1;
								end else if (req.a[30:0] == 31'd0) begin
									res_q  <= {req.a[31], 63'd0};
									done_q <= 1'b1;
								end else begin
									sign_q <= req.a[31];
									m_q    <= {f_e != 8'd0, f_f, 104'd0};
									eb_q   <= $signed({6'd0, f_ee}) + 14'sd896;
									st_q   <= S_NORM;
								end
							end
							FOP_CVTI: begin
								if (req.a[7:0] == 8'd0) begin
									res_q  <= 64'd0;
									done_q <= 1'b1;
								end else begin
									sign_q <= 1'b0;
									m_q    <= {req.a[7:0], 120'd0};
									eb_q   <= 14'sd1030;
									st_q   <= S_NORM;
								end
							end
							default: ;
						endcase
					end
				end
				S_ALIGN: begin
					if (al_sum == 128'd0) begin
						res_q  <= {zs_q, 63'd0};
						done_q <= 1'b1;
						st_q   <= S_IDLE;
					end else begin
						m_q  <= al_sum;
						st_q <= S_NORM;
					end
				end
				S_MUL: begin
					if (cnt_q != 3'd0)
						m_q <= m_q + ppadd;
					pp_q   <= pp_n;
					ppsh_q <= {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
					cnt_q  <= cnt_q + 3'd1;
					if (cnt_q == 3'd4)
						st_q <= S_NORM;
				end
				S_NORM: begin
					if (eb_q < 14'sd1) begin
						// underflow: shift right keeping a sticky bit
						if (eb_q < -14'sd127) begin
							m_q  <= {127'd0, |m_q};
							eb_q <= 14'sd1;
						end else if (eb_q <= -14'sd15) begin
							m_q  <= {16'd0, m_q[127:17], m_q[16] | (|m_q[15:0])};
							eb_q <= eb_q + 14'sd16;
						end else begin
							m_q  <= {1'b0, m_q[127:2], m_q[1] | m_q[0]};
							eb_q <= eb_q + 14'sd1;
						end
					end else if (!m_q[127] && (eb_q > 14'sd1)) begin
						if ((m_q[127:112] == 16'd0) && (eb_q > 14'sd16)) begin
							m_q  <= {m_q[111:0], 16'd0};
							eb_q <= eb_q - 14'sd16;
						end else begin
							m_q  <= {m_q[126:0], 1'b0};
							eb_q <= eb_q - 14'sd1;
						end
					end else begin
						st_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					res_q  <= ovf ? {sign_q, 11'h7FF, 52'd0} : {sign_q, rnd};
					done_q <= 1'b1;
					st_q   <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule

// ----- rtl/polyfit_frame_angle_decoder.sv -----
// Header, chunk start, coefficient words and error words need no binary64 operation.
// A literal sample is one widen plus one add, and two more adds when the offset steps
// by 2*pi; an emit converts the index and widens the top coefficient, then for each
// further coefficient multiplies, widens and adds, then adds the offset as above; all
// runs on the shared binary64 unit. Throughput: one word at a time; ready is low while a sample is computed.
// Reset: arst_n clears frame state, offset and the output register at once.
module polyfit_frame_angle_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  element_count,
	input  logic [7:0]  parameter_count,
	input  logic [31:0] parameter_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] sample_bits,
	output logic        last_in_frame,
	output logic        error
);
	import pfad_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_X    = 10'b0000000010,
		ST_ACC0 = 10'b0000000100,
		ST_MUL  = 10'b0000001000,
		ST_CF   = 10'b0000010000,
		ST_ADD  = 10'b0000100000,
		ST_LCV  = 10'b0001000000,
		ST_W1   = 10'b0010000000,
		ST_W2   = 10'b0100000000,
		ST_W3   = 10'b1000000000
	} st_t;

	st_t             st_q;
	logic            issued_q;
	logic [7:0]      fe_q, fp_q, pr_q, si_q, idx_q;
	logic            pm_q;
	logic [63:0]     off_q, acc_q, x_q, cf_q;
	logic [31:0]     lit_q;
	logic [CNT_W-1:0] k_q;
	logic            last_q;
	logic            adj_sub_q;
	logic [31:0]     coef_q [MAX_COEFFS];
	logic            ov_q, ol_q, oe_q;
	logic [63:0]     os_q;

	fpu_req_t req;
	fpu_rsp_t rsp;

	pfad_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	logic             accept;
	logic             out_free;
	logic [CNT_W-1:0] k_m1;
	logic [31:0]      coef_rd;
	logic             big_frame;

	assign out_free  = !ov_q || out_ready;
	assign in_ready  = (st_q == ST_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign k_m1      = k_q - CNT_W'(1);
	assign coef_rd   = coef_q[k_m1[COEF_AW-1:0]];
	assign big_frame = (fp_q > 8'(MAX_COEFFS));

	// wrap compare on v + offset
	logic [63:0] s;
	logic        s_nan, s_neg, s_ge;
	assign s     = rsp.res;
	assign s_nan = (s[62:52] == 11'h7FF) && (s[51:0] != 52'd0);
	assign s_neg = s[63] && (s[62:0] != 63'd0) && !s_nan;
	assign s_ge  = !s[63] && !s_nan && (s[62:0] >= TWO_PI_BITS[62:0]);

	// operation issue
	always_comb begin
		req.start = 1'b0;
		req.op    = FOP_ADD;
		req.a     = acc_q;
		req.b     = off_q;
		unique case (st_q)
			ST_IDLE: ;
			ST_X: begin
				req.start = !issued_q;
				req.op    = FOP_CVTI;
				req.a     = {56'd0, idx_q};
			end
			ST_ACC0, ST_CF: begin
				req.start = !issued_q;
				req.op    = FOP_CVTF;
				req.a     = {32'd0, coef_rd};
			end
			ST_MUL: begin
				req.start = !issued_q;
				req.op    = FOP_MUL;
				req.a     = x_q;
				req.b     = acc_q;
			end
			ST_ADD: begin
				req.start = !issued_q;
				req.a     = cf_q;
				req.b     = acc_q;
			end
			ST_LCV: begin
				req.start = !issued_q;
				req.op    = FOP_CVTF;
				req.a     = {32'd0, lit_q};
			end
			ST_W1, ST_W3: begin
				req.start = !issued_q;
			end
			ST_W2: begin
				req.start = !issued_q;
				req.a     = off_q;
				req.b     = {adj_sub_q, TWO_PI_BITS[62:0]};
			end
			default: ;
		endcase
	end

	// coefficient store
	always_ff @(posedge clk) begin
		if (accept && (kind == KIND_PARAM) && (pr_q < fp_q) && pm_q &&
		    (pr_q < 8'(MAX_COEFFS)))
			coef_q[pr_q[COEF_AW-1:0]] <= parameter_bits;
	end

	// frame control and sample sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			issued_q  <= 1'b0;
			fe_q      <= 8'd0;
			fp_q      <= 8'd0;
			pr_q      <= 8'd0;
			si_q      <= 8'd0;
			pm_q      <= 1'b0;
			off_q     <= 64'd0;
			idx_q     <= 8'd0;
			acc_q     <= 64'd0;
			x_q       <= 64'd0;
			cf_q      <= 64'd0;
			lit_q     <= 32'd0;
			k_q       <= '0;
			last_q    <= 1'b0;
			adj_sub_q <= 1'b0;
			ov_q      <= 1'b0;
			os_q      <= 64'd0;
			ol_q      <= 1'b0;
			oe_q      <= 1'b0;
		end else begin
			if (ov_q && out_ready)
				ov_q <= 1'b0;
			if (st_q != ST_IDLE) begin
				if (!issued_q)
					issued_q <= 1'b1;
				else if (rsp.done)
					issued_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						case (kind)
							KIND_CHUNK: begin
								off_q <= 64'd0;
								fe_q  <= 8'd0;
								fp_q  <= 8'd0;
								pr_q  <= 8'd0;
								si_q  <= 8'd0;
								pm_q  <= 1'b0;
							end
							KIND_HEADER: begin
								fe_q <= element_count;
								fp_q <= parameter_count;
								pr_q <= 8'd0;
								si_q <= 8'd0;
								pm_q <= element_count > parameter_count;
								if ((element_count > parameter_count) &&
								    (parameter_count > 8'(MAX_COEFFS))) begin
									ov_q <= 1'b1;
									os_q <= 64'd0;
									ol_q <= 1'b0;
									oe_q <= 1'b1;
								end
							end
							KIND_PARAM: begin
								if (pr_q >= fp_q) begin
									ov_q <= 1'b1;
									os_q <= 64'd0;
									ol_q <= 1'b0;
									oe_q <= 1'b1;
								end else begin
									pr_q <= pr_q + 8'd1;
									if (!pm_q && (pr_q < fe_q)) begin
										si_q   <= pr_q + 8'd1;
										last_q <= (pr_q + 8'd1) == fe_q;
										lit_q  <= parameter_bits;
										st_q   <= ST_LCV;
									end
								end
							end
							KIND_EMIT: begin
								if (!pm_q || big_frame || (pr_q != fp_q) || (si_q >= fe_q)) begin
									ov_q <= 1'b1;
									os_q <= 64'd0;
									ol_q <= 1'b0;
									oe_q <= 1'b1;
								end else begin
									idx_q  <= si_q;
									si_q   <= si_q + 8'd1;
									last_q <= (si_q + 8'd1) == fe_q;
									if (fp_q == 8'd0) begin
										acc_q <= 64'd0;
										st_q  <= ST_W1;
									end else begin
										k_q  <= fp_q[CNT_W-1:0];
										st_q <= ST_X;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_X: begin
					if (issued_q && rsp.done) begin
						x_q  <= rsp.res;
						st_q <= ST_ACC0;
					end
				end
				ST_ACC0: begin
					if (issued_q && rsp.done) begin
						acc_q <= rsp.res;
						k_q   <= k_m1;
						st_q  <= (k_m1 == '0) ? ST_W1 : ST_MUL;
					end
				end
				ST_MUL: begin
					if (issued_q && rsp.done) begin
						acc_q <= rsp.res;
						st_q  <= ST_CF;
					end
				end
				ST_CF: begin
					if (issued_q && rsp.done) begin
						cf_q <= rsp.res;
						st_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (issued_q && rsp.done) begin
						acc_q <= rsp.res;
						k_q   <= k_m1;
						st_q  <= (k_m1 == '0) ? ST_W1 : ST_MUL;
					end
				end
				ST_LCV: begin
					if (issued_q && rsp.done) begin
						acc_q <= rsp.res;
						st_q  <= ST_W1;
					end
				end
				ST_W1: begin
					if (issued_q && rsp.done) begin
						if (s_neg || s_ge) begin
							adj_sub_q <= !s_neg;
							st_q      <= ST_W2;
						end else begin
							ov_q <= 1'b1;
							os_q <= s;
							ol_q <= last_q;
							oe_q <= 1'b0;
							st_q <= ST_IDLE;
						end
					end
				end
				ST_W2: begin
					if (issued_q && rsp.done) begin
						off_q <= rsp.res;
						st_q  <= ST_W3;
					end
				end
				ST_W3: begin
					if (issued_q && rsp.done) begin
						ov_q <= 1'b1;
						os_q <= rsp.res;
						ol_q <= last_q;
						oe_q <= 1'b0;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = ov_q;
	assign sample_bits   = os_q;
	assign last_in_frame = ol_q;
	assign error         = oe_q;

endmodule

// ----- rtl/pfad_checker.sv -----
// Port-level checks for the frame angle decoder.
module pfad_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  kind,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] sample_bits,
	input logic        last_in_frame,
	input logic        error
);
	import pfad_pkg::*;

	// an error word carries no sample
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> (sample_bits == 64'd0) && !last_in_frame)
		else $error("error word with sample payload");

	// a new word is only taken when the output slot frees up
	a_ready_slot: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid || out_ready)
		else $error("input taken while output blocked");

	// chunk start never produces a word
	a_chunk_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (kind == KIND_CHUNK) |=> !out_valid)
		else $error("chunk start produced a word");

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_bits) && $stable(error))
		else $error("output word changed while stalled");

endmodule

bind polyfit_frame_angle_decoder pfad_checker u_pfad_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.kind          (kind),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.sample_bits   (sample_bits),
	.last_in_frame (last_in_frame),
	.error         (error)
);

// ----- sim/tb_polyfit_frame_angle_decoder.sv -----
`timescale 1ns / 100ps

module tb_polyfit_frame_angle_decoder;
	import pfad_pkg::*;

	typedef struct {
		logic [63:0] bits;
		logic        last;
		logic        err;
	} angle_word_t;

	// holds predicted output words in order and compares arriving ones
	class sample_scoreboard;
		angle_word_t pending_q[$];
		int          fails;

		function new();
			fails = 0;
		endfunction

		function void note_input(angle_word_t w);
			pending_q.push_back(w);
		endfunction

		function bit is_nan(logic [63:0] b);
			return (b[62:52] == 11'h7FF) && (b[51:0] != 0);
		endfunction

		function void check_output(logic [63:0] bits, logic last, logic err);
			angle_word_t w;
			bit          bits_ok;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected word bits=%h last=%b err=%b", $time, bits, last, err);
				fails++;
				return;
			end
			w = pending_q.pop_front();
			// NaN payloads are not pinned down; only the class must match
			bits_ok = (w.bits === bits) || (is_nan(w.bits) && is_nan(bits));
			if (!bits_ok) begin
				$display("%0t: sample_bits expected %h actual %h", $time, w.bits, bits);
				fails++;
			end
			if (w.last !== last) begin
				$display("%0t: last_in_frame expected %b actual %b", $time, w.last, last);
				fails++;
			end
			if (w.err !== err) begin
				$display("%0t: error expected %b actual %b", $time, w.err, err);
				fails++;
			end
		endfunction

		function int pending();
			return pending_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	kind_t       kind;
	logic [7:0]  element_count;
	logic [7:0]  parameter_count;
	logic [31:0] parameter_bits;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] sample_bits;
	logic        last_in_frame;
	logic        error;

	polyfit_frame_angle_decoder uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .element_count(element_count),
		.parameter_count(parameter_count), .parameter_bits(parameter_bits),
		.out_valid(out_valid), .out_ready(out_ready),
		.sample_bits(sample_bits), .last_in_frame(last_in_frame), .error(error)
	);

	sample_scoreboard sb = new();

	// predictor state
	logic [31:0] coef_mem [MAX_COEFFS];
	logic [7:0]  n_elem, n_param, n_recv, emit_idx;
	bit          poly_mode;
	real         offset;

	bit quiet_phase;
	bit hold_req;
	bit drained;
	int accept_idle;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// exact binary32 to binary64 widening, NaNs quieted
	function automatic logic [63:0] widen(logic [31:0] f);
		logic [10:0] e64;
		logic [51:0] m64;
		logic [22:0] m;
		int          p;
		m = f[22:0];
		if (f[30:23] == 8'hFF) begin
			e64 = 11'h7FF;
			m64 = {m, 29'd0};
			if (m != 0) m64[51] = 1'b1;
		end else if (f[30:23] == 0) begin
			if (m == 0) begin
				e64 = 0;
				m64 = 0;
			end else begin
				p = 22;
				while (!m[p]) p--;
				e64 = 11'(1023 - 149 + p);
				m64 = 52'({29'd0, m} << (52 - p));
			end
		end else begin
			e64 = 11'(f[30:23] - 127 + 1023);
			m64 = {m, 29'd0};
		end
		return {f[31], e64, m64};
	endfunction

	function automatic angle_word_t wrap_sample(real v, bit last);
		angle_word_t w;
		real         tp;
		tp = $bitstoreal(TWO_PI_BITS);
		if (v + offset < 0.0) offset = offset + tp;
		else if (v + offset >= tp) offset = offset - tp;
		w.bits = $realtobits(v + offset);
		w.last = last;
		w.err  = 1'b0;
		return w;
	endfunction

	function automatic void predict_word(kind_t k, logic [7:0] e, logic [7:0] p,
			logic [31:0] b);
		angle_word_t bad;
		real         acc, x;
		int          pos;
		bad.bits = 0;
		bad.last = 0;
		bad.err  = 1;
		case (k)
			KIND_CHUNK: begin
				offset = 0.0;
				n_elem = 0; n_param = 0; n_recv = 0; emit_idx = 0; poly_mode = 0;
			end
			KIND_HEADER: begin
				n_elem = e; n_param = p; n_recv = 0; emit_idx = 0;
				poly_mode = e > p;
				if (poly_mode && p > MAX_COEFFS) sb.note_input(bad);
			end
			KIND_PARAM: begin
				pos = n_recv;
				if (pos >= n_param) begin
					sb.note_input(bad);
				end else begin
					n_recv = 8'(pos + 1);
					if (poly_mode) begin
						if (pos < MAX_COEFFS) coef_mem[pos] = b;
					end else if (pos < n_elem) begin
						emit_idx = 8'(pos + 1);
						sb.note_input(wrap_sample($bitstoreal(widen(b)), pos + 1 == n_elem));
					end
				end
			end
			default: begin
				if (!poly_mode || n_param > MAX_COEFFS || n_recv != n_param ||
						emit_idx >= n_elem) begin
					sb.note_input(bad);
				end else begin
					// Horner in binary64, highest order first
					x = emit_idx;
					acc = 0.0;
					if (n_param != 0) begin
						acc = $bitstoreal(widen(coef_mem[n_param - 1]));
						for (int j = n_param - 1; j > 0; j--)
							acc = $bitstoreal(widen(coef_mem[j - 1])) + x * acc;
					end
					sb.note_input(wrap_sample(acc, emit_idx + 1 == n_elem));
					emit_idx = emit_idx + 1;
				end
			end
		endcase
	endfunction

	// offer one word, with an optional random gap first
	task automatic send_word(kind_t k, logic [7:0] e, logic [7:0] p, logic [31:0] b);
		int gap;
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		kind            <= k;
		element_count   <= e;
		parameter_count <= p;
		parameter_bits  <= b;
		do @(posedge clk); while (!in_ready);
		predict_word(k, e, p, b);
	endtask

	function automatic logic [31:0] rand_coef();
		if ($urandom_range(0, 9) == 0) return $urandom();
		return {1'($urandom()), 8'($urandom_range(117, 129)), 23'($urandom())};
	endfunction

	function automatic logic [31:0] rand_angle();
		if ($urandom_range(0, 9) == 0) return $urandom();
		return {1'($urandom()), 8'($urandom_range(100, 130)), 23'($urandom())};
	endfunction

	task automatic poly_frame(int e, int p, int emits);
		send_word(KIND_HEADER, 8'(e), 8'(p), $urandom());
		for (int i = 0; i < p; i++)
			send_word(KIND_PARAM, 8'($urandom()), 8'($urandom()), rand_coef());
		for (int i = 0; i < emits; i++)
			send_word(KIND_EMIT, 8'($urandom()), 8'($urandom()), $urandom());
	endtask

	task automatic literal_frame(int e, int p);
		send_word(KIND_HEADER, 8'(e), 8'(p), $urandom());
		for (int i = 0; i < p; i++)
			send_word(KIND_PARAM, 8'($urandom()), 8'($urandom()), rand_angle());
	endtask

	// sender
	initial begin
		int sent;
		int e, p, r;
		in_valid = 0; kind = KIND_CHUNK; element_count = 0; parameter_count = 0;
		parameter_bits = 0; quiet_phase = 0; hold_req = 0; drained = 0;
		n_elem = 0; n_param = 0; n_recv = 0; emit_idx = 0; poly_mode = 0; offset = 0.0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed part
		send_word(KIND_CHUNK, 0, 0, 0);
		send_word(KIND_HEADER, 3, 2, 0);
		send_word(KIND_EMIT, 0, 0, 0);                   // emit before coefficients
		send_word(KIND_PARAM, 0, 0, 32'h3F800000);
		send_word(KIND_PARAM, 0, 0, 32'hBFC00000);
		repeat (4) send_word(KIND_EMIT, 8'hFF, 8'hFF, 32'hFFFFFFFF); // last one is past the end
		send_word(KIND_PARAM, 0, 0, 0);                  // excess word
		send_word(KIND_HEADER, 2, 0, 0);                 // empty polynomial
		repeat (2) send_word(KIND_EMIT, 0, 0, 0);
		send_word(KIND_HEADER, 2, 4, 0);                 // literal with excess words
		send_word(KIND_PARAM, 0, 0, 32'h7FC00000);       // NaN
		send_word(KIND_PARAM, 0, 0, 32'h00000001);       // denormal
		send_word(KIND_PARAM, 0, 0, 32'hFFFFFFFF);
		send_word(KIND_PARAM, 0, 0, 32'h7F800000);
		send_word(KIND_EMIT, 0, 0, 0);                   // emit in literal mode
		send_word(KIND_HEADER, 20, 17, 0);               // too many coefficients
		send_word(KIND_EMIT, 0, 0, 0);
		send_word(KIND_HEADER, 0, 0, 0);
		send_word(KIND_PARAM, 0, 0, 32'hC1200000);
		send_word(KIND_CHUNK, 8'hFF, 8'hFF, 32'hFFFFFFFF);
		literal_frame(1, 1);
		poly_frame(255, 16, 1);
		send_word(KIND_CHUNK, 0, 0, 0);

		sent = 0;
		while (sent < 1400) begin
			if (sent > 1250) quiet_phase = 1;
			if (sent >= 400 && !hold_req) begin
				// long receiver hold while literal samples keep coming
				hold_req = 1;
				literal_frame(12, 12);
				sent += 13;
			end else if (sent >= 700 && !drained) begin
				// sender pause until every expected word is out
				drained = 1;
				in_valid <= 1'b0;
				while (sb.pending() != 0) @(posedge clk);
				literal_frame(3, 3);
				sent += 4;
			end else begin
				r = $urandom_range(0, 19);
				if (r < 8) begin
					p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 5);
					e = p + $urandom_range(1, 8);
					poly_frame(e, p, e + $urandom_range(0, 1));
					sent += 1 + p + e;
				end else if (r < 14) begin
					e = $urandom_range(0, 8);
					p = e + $urandom_range(0, 2);
					literal_frame(e, p);
					sent += 1 + p;
				end else if (r < 15) begin
					poly_frame($urandom_range(18, 30), $urandom_range(17, 17), 2);
					sent += 20;
				end else if (r < 16) begin
					send_word(KIND_CHUNK, 8'($urandom()), 8'($urandom()), $urandom());
					sent += 1;
				end else begin
					// noise, kept short so random headers cannot force long frames
					send_word(kind_t'($urandom_range(1, 2)), 8'($urandom()), 8'($urandom()),
						$urandom());
					sent += 1;
				end
			end
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.fails == 0 && sb.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// receiver ready pattern
	initial begin
		int n;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req && n != -1) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				n = -1;
			end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_output(sample_bits, last_in_frame, error);
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			accept_idle <= 0;
		end else begin
			accept_idle <= accept_idle + 1;
			if (accept_idle > 20000) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

endmodule

// ----- files.f -----
rtl/pfad_pkg.sv
rtl/pfad_fpu.sv
rtl/polyfit_frame_angle_decoder.sv
rtl/pfad_checker.sv
sim/tb_polyfit_frame_angle_decoder.sv
